@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/slpq_pkg.sv @@
`default_nettype none
package slpq_pkg;

    localparam int DEPTH  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = 6;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;

    // Output word: count, position, element, padded to whole bytes.
    localparam int ODATA_RAW = CNT_W + POS_W + VAL_W;
    localparam int ODATA_W   = ((ODATA_RAW + 7) / 8) * 8;
    localparam int OUSER_W   = 1 + ST_W;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [ST_W-1:0] ST_OK          = 2'd0;
    localparam logic [ST_W-1:0] ST_NOTHING_RM  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL        = 2'd2;

    typedef struct packed {
        logic capture;
        logic update;
        logic load;
    } slpq_cmd_t;

    typedef struct packed {
        logic out_free;
        logic emit_last;
    } slpq_stat_t;

endpackage
`default_nettype wire

@@ sv/slpq_ctrl.sv @@
`default_nettype none
module slpq_ctrl
    import slpq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire slpq_stat_t stat,
    output slpq_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_UPDATE = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // one word per free slot in the output register
                if (stat.out_free)
                begin
                    cmd.load = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/slpq_dp.sv @@
`default_nettype none
module slpq_dp
    import slpq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire slpq_cmd_t          cmd,
    output slpq_stat_t              stat,
    input  wire logic               in_req,
    input  wire logic [VAL_W-1:0]   in_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [ODATA_W-1:0]      out_data,
    output logic [OUSER_W-1:0]      out_user,
    output logic                    out_last
);

    logic                    req_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [ST_W-1:0]         status_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic signed [VAL_W-1:0] store_reg  [DEPTH];
    logic signed [VAL_W-1:0] store_next [DEPTH];
    logic [DEPTH-1:0]        lt;

    logic                    out_valid_reg;
    logic [ODATA_W-1:0]      out_data_reg;
    logic [OUSER_W-1:0]      out_user_reg;
    logic                    out_last_reg;

    logic                    empty;
    logic                    full;
    logic                    emit_last;
    logic signed [VAL_W-1:0] elem;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));

    // Each cell knows whether it stays, takes the new value or takes its lower neighbor.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign lt[i] = (CNT_W'(i) < count_reg) && (store_reg[i] < val_reg);
        if (i == 0)
        begin : g_first
            assign store_next[i] = lt[i] ? store_reg[i] : val_reg;
        end
        else
        begin : g_rest
            assign store_next[i] = lt[i]     ? store_reg[i] :
                                   lt[i-1]   ? val_reg      : store_reg[i-1];
        end
    end

    assign emit_last = empty || (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
    assign elem      = empty ? '0 : store_reg[idx_reg];

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.emit_last = emit_last;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= in_req;
            val_reg <= in_value;
        end
        if (cmd.update && req_reg == REQ_INSERT && !full)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                store_reg[i] <= store_next[i];
            end
        end
        if (cmd.load)
        begin
            out_data_reg <= ODATA_W'({elem, (empty ? POS_W'(0) : POS_W'(idx_reg)),
                                      count_reg});
            out_user_reg <= {status_reg, !empty};
            out_last_reg <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            status_reg    <= ST_OK;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                idx_reg <= '0;
                if (req_reg == REQ_REMOVE)
                begin
                    if (empty)
                    begin
                        status_reg <= ST_NOTHING_RM;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                        count_reg  <= count_reg - CNT_W'(1);
                    end
                end
                else if (full)
                begin
                    status_reg <= ST_FULL;
                end
                else
                begin
                    status_reg <= ST_OK;
                    count_reg  <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.load)
            begin
                idx_reg <= emit_last ? '0 : idx_reg + IDX_W'(1);
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

@@ sv/sorted_list_priority_queue.sv @@
// Sorted-list priority queue of up to 32 signed 32-bit values, smallest first.
// Input stream: s_tuser selects insert (0) or remove-largest (1), s_tdata holds
// the value. Output stream: one word per stored element after each request,
// smallest first, tlast on the final word; an empty list gives one word with
// has_element low.
// Timing: a request is taken in the idle state, the list is updated in the next
// state (all cells shift in parallel), then one word per cycle leaves through
// the output register while the receiver does not stall it. The words of a
// request are read out serially, one per stored value.
// s_tready is high only between requests; the next request is taken while the
// final word of the previous one still waits in the output register.
// Reset empties the list and drops any pending word. A stalled receiver
// holds the output register, and the readout waits with it.
`default_nettype none
module sorted_list_priority_queue
    import slpq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [VAL_W-1:0]     s_tdata,   // value
    input  wire logic [0:0]           s_tuser,   // req_type
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [ODATA_W-1:0]        m_tdata,   // count, position, element, zero pad
    output logic [OUSER_W-1:0]        m_tuser,   // has_element, status
    output logic                      m_tlast
);

    slpq_cmd_t  cmd;
    slpq_stat_t stat;

    slpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    slpq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_req    (s_tuser[0]),
        .in_value  (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule
`default_nettype wire

@@ sv/slpq_check.sv @@
`default_nettype none
`include "assert_macros.svh"
module slpq_check
    import slpq_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [ODATA_W-1:0]   m_tdata,
    input wire logic [OUSER_W-1:0]   m_tuser,
    input wire logic                 m_tlast
);

    // stalled word holds
    `ASSERT_NXT(a_hold, clk, rst_n, m_tvalid && !m_tready,
                m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    // one request at a time
    `ASSERT_NXT(a_one_req, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // an empty report is a single word
    `ASSERT_IMP(a_empty_last, clk, rst_n, m_tvalid && !m_tuser[0], m_tlast)
    // reported rank stays below the count
    `ASSERT_IMP(a_rank, clk, rst_n, m_tvalid && m_tuser[0],
                {1'b0, m_tdata[CNT_W+POS_W-1:CNT_W]} < m_tdata[CNT_W-1:0])

endmodule

bind sorted_list_priority_queue slpq_check u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

@@ verif/tb_sorted_list_priority_queue.sv @@
`timescale 1ns / 1ps

module tb_sorted_list_priority_queue;
    import slpq_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] element;
        logic             has_element;
        logic [ST_W-1:0]  status;
        logic             last;
    } list_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [VAL_W-1:0]     s_tdata;    // value
    logic [0:0]           s_tuser;    // req_type
    logic                 m_tvalid;
    logic                 m_tready;
    logic [ODATA_W-1:0]   m_tdata;    // count, position, element, zero pad
    logic [OUSER_W-1:0]   m_tuser;    // has_element, status
    logic                 m_tlast;

    sorted_list_priority_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Shadow copy of the sorted list
    logic [VAL_W-1:0] held_vals [DEPTH];
    int               held_count;
    list_word_t       pending_words [$];

    int error_count;
    int requests_sent;
    int words_checked;
    int full_drops;
    int empty_removes;
    int peak_count;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic void push_word(int cnt, int pos, logic [VAL_W-1:0] elem, logic has,
                                      logic [ST_W-1:0] st, logic lst);
        list_word_t w;
        w.count       = cnt[CNT_W-1:0];
        w.position    = pos[POS_W-1:0];
        w.element     = elem;
        w.has_element = has;
        w.status      = st;
        w.last        = lst;
        pending_words.push_back(w);
    endfunction

    function automatic void push_list(logic [ST_W-1:0] st);
        if (held_count == 0)
            push_word(0, 0, '0, 1'b0, st, 1'b1);
        else
            for (int i = 0; i < held_count; i++)
                push_word(held_count, i, held_vals[i], 1'b1, st, i + 1 == held_count);
    endfunction

    function automatic void predict_request(logic rt, logic [VAL_W-1:0] v);
        int slot;
        requests_sent++;
        if (rt == REQ_REMOVE)
        begin
            if (held_count == 0)
            begin
                empty_removes++;
                push_word(0, 0, '0, 1'b0, ST_NOTHING_RM, 1'b1);
            end
            else
            begin
                held_count--;
                push_list(ST_OK);
            end
        end
        else if (held_count >= DEPTH)
        begin
            full_drops++;
            push_list(ST_FULL);
        end
        else
        begin
            // equal values go ahead of the ones already held
            slot = 0;
            while (slot < held_count && $signed(held_vals[slot]) < $signed(v))
                slot++;
            for (int i = held_count; i > slot; i--)
                held_vals[i] = held_vals[i-1];
            held_vals[slot] = v;
            held_count++;
            if (held_count > peak_count)
                peak_count = held_count;
            push_list(ST_OK);
        end
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(7))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = $urandom_range(15) - 8;
            3: v = {$urandom_range(1) ? 24'hFFFFFF : 24'h000000, 8'($urandom)};
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Enter at a clock edge; return at the edge where the word was taken
    task automatic send_request(input logic rt, input logic [VAL_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= rt;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_request(rt, v);
    endtask

    task automatic test_edge_values();
        send_request(REQ_REMOVE, 32'h0000_0000);
        send_request(REQ_INSERT, 32'h0000_0000);
        send_request(REQ_INSERT, 32'h7FFF_FFFF);
        send_request(REQ_INSERT, 32'h8000_0000);
        send_request(REQ_INSERT, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h0000_0001);
        send_request(REQ_INSERT, 32'h7FFF_FFFF);
        send_request(REQ_INSERT, 32'h8000_0000);
        send_request(REQ_INSERT, 32'h0000_0000);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF);
        send_request(REQ_REMOVE, 32'h8000_0000);
        send_request(REQ_INSERT, 32'h8000_0001);
        send_request(REQ_INSERT, 32'h7FFF_FFFE);
        send_request(REQ_REMOVE, 32'h7FFF_FFFF);
        send_request(REQ_REMOVE, 32'hAAAA_5555);
        while (held_count > 0)
            send_request(REQ_REMOVE, 32'h5555_AAAA);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF);
    endtask

    task automatic test_full_list();
        while (held_count < DEPTH)
            send_request(REQ_INSERT, pick_value());
        send_request(REQ_INSERT, 32'h8000_0000);
        send_request(REQ_INSERT, 32'h7FFF_FFFF);
        send_request(REQ_INSERT, pick_value());
        while (held_count > 0)
            send_request(REQ_REMOVE, pick_value());
        send_request(REQ_REMOVE, pick_value());
    endtask

    // Bursts that lean toward filling, draining or holding the list level
    task automatic test_random_mix(input int n_requests);
        int sent;
        int burst_left;
        int insert_pct;
        sent       = 0;
        burst_left = 0;
        insert_pct = 50;
        while (sent < n_requests)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(8, 40);
                case ($urandom_range(2))
                    0: insert_pct = 85;
                    1: insert_pct = 20;
                    default: insert_pct = 55;
                endcase
            end
            send_request(($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE,
                         pick_value());
            burst_left--;
            sent++;
        end
    endtask

    function automatic void compare_field(string name, logic [VAL_W-1:0] want,
                                          logic [VAL_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_words
        list_word_t want;
        list_word_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.count       = m_tdata[0 +: CNT_W];
            got.position    = m_tdata[CNT_W +: POS_W];
            got.element     = m_tdata[CNT_W + POS_W +: VAL_W];
            got.has_element = m_tuser[0];
            got.status      = m_tuser[1 +: ST_W];
            got.last        = m_tlast;
            words_checked++;
            if (pending_words.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected word, expected none, got 0x%0h", $time, got);
            end
            else
            begin
                want = pending_words.pop_front();
                compare_field("count", want.count, got.count);
                compare_field("position", want.position, got.position);
                compare_field("element", want.element, got.element);
                compare_field("has_element", want.has_element, got.has_element);
                compare_field("status", want.status, got.status);
                compare_field("last", want.last, got.last);
            end
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Abort when neither side moves a word for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        held_count    = 0;
        requests_sent = 0;
        full_drops    = 0;
        empty_removes = 0;
        peak_count    = 0;
        send_idle_pct = 24;
        recv_idle_pct = 78;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_values();
        test_full_list();
        test_random_mix(140);
        send_idle_pct = 78;
        recv_idle_pct = 24;
        test_random_mix(140);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(140);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests and checked %0d list words; the list peaked at %0d values.",
                 requests_sent, words_checked, peak_count);
        $display("Inserts dropped on a full list: %0d, removes on an empty list: %0d.",
                 full_drops, empty_removes);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
